@@ design/ehss_pkg.sv @@
package ehss_pkg;

    localparam int KIND_W  = 3;
    localparam int TYPE_W  = 2;
    localparam int HOUR_W  = 5;
    localparam int DAY_W   = 3;
    localparam int BIN_W   = 32;
    localparam int TOTAL_W = 42;

    localparam logic [BIN_W-1:0]   BIN_MAX   = '1;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

    localparam logic [KIND_W-1:0] K_RECORD   = 3'd0;
    localparam logic [KIND_W-1:0] K_BIN      = 3'd1;
    localparam logic [KIND_W-1:0] K_TOTAL    = 3'd2;
    localparam logic [KIND_W-1:0] K_HOUR     = 3'd3;
    localparam logic [KIND_W-1:0] K_TYPE     = 3'd4;
    localparam logic [KIND_W-1:0] K_TYPE_DAY = 3'd5;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_WALK,
        S_DRAIN,
        S_EMIT,
        S_REC_RD,
        S_REC_WR
    } t_state;

    typedef struct packed {
        logic clr;
        logic add;
        logic emit;
    } t_acc_ctl;

endpackage

@@ design/ehss_ram.sv @@
module ehss_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 576
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_addr,
    input  logic [WIDTH-1:0]                       i_wdata,
    output logic [WIDTH-1:0]                       o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/ehss_seq.sv @@
module ehss_seq #(
    parameter int DAYS       = 8,
    parameter int HOURS      = 24,
    parameter int TYPE_COUNT = 3
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    output logic                       o_busy,
    input  logic [ehss_pkg::KIND_W-1:0] i_kind,
    input  logic [ehss_pkg::TYPE_W-1:0] i_op_type,
    input  logic [ehss_pkg::HOUR_W-1:0] i_hour,
    input  logic [ehss_pkg::DAY_W-1:0]  i_day,
    input  logic [ehss_pkg::BIN_W-1:0]  i_rdata,
    output logic                       o_we,
    output logic [(DAYS*HOURS*TYPE_COUNT > 1 ? $clog2(DAYS*HOURS*TYPE_COUNT) : 1)-1:0] o_addr,
    output logic [ehss_pkg::BIN_W-1:0]  o_wdata,
    output ehss_pkg::t_acc_ctl          o_ctl
);
    import ehss_pkg::*;

    localparam int DEPTH = DAYS * HOURS * TYPE_COUNT;
    localparam int AW    = DEPTH > 1 ? $clog2(DEPTH) : 1;
    localparam int DW    = DAYS > 1 ? $clog2(DAYS) : 1;
    localparam int HW    = HOURS > 1 ? $clog2(HOURS) : 1;
    localparam int TW    = TYPE_COUNT > 1 ? $clog2(TYPE_COUNT) : 1;

    localparam logic [DW-1:0] D_LAST = DW'(DAYS - 1);
    localparam logic [HW-1:0] H_LAST = HW'(HOURS - 1);
    localparam logic [TW-1:0] T_LAST = TW'(TYPE_COUNT - 1);

    t_state        r_state, n_state;
    logic [DW-1:0] r_d, n_d;
    logic [HW-1:0] r_h, n_h;
    logic [TW-1:0] r_t, n_t;
    logic          r_fix_d, n_fix_d;
    logic          r_fix_h, n_fix_h;
    logic          r_fix_t, n_fix_t;
    logic          r_rd_pend, n_rd_pend;

    logic d_ok, h_ok, t_ok;
    logic d_end, h_end, t_end, all_end;
    logic accept;

    assign d_ok = 32'(i_day) < DAYS;
    assign h_ok = 32'(i_hour) < HOURS;
    assign t_ok = 32'(i_op_type) < TYPE_COUNT;

    // a fixed dimension starts and ends at its selector
    assign d_end   = r_fix_d || (r_d == D_LAST);
    assign h_end   = r_fix_h || (r_h == H_LAST);
    assign t_end   = r_fix_t || (r_t == T_LAST);
    assign all_end = d_end && h_end && t_end;

    assign accept = i_start && (r_state == S_IDLE);
    assign o_busy = (r_state != S_IDLE);
    assign o_addr = AW'((32'(r_d) * HOURS + 32'(r_h)) * TYPE_COUNT + 32'(r_t));

    always_comb begin
        n_state   = r_state;
        n_d       = r_d;
        n_h       = r_h;
        n_t       = r_t;
        n_fix_d   = r_fix_d;
        n_fix_h   = r_fix_h;
        n_fix_t   = r_fix_t;
        n_rd_pend = 1'b0;
        o_we      = 1'b0;
        o_wdata   = '0;
        o_ctl     = '0;
        o_ctl.add = r_rd_pend;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_ctl.clr = 1'b1;
                    n_fix_d   = 1'b1;
                    n_fix_h   = 1'b1;
                    n_fix_t   = 1'b1;
                    n_state   = S_IDLE;
                    unique case (i_kind)
                        K_RECORD: begin
                            if (d_ok && h_ok && t_ok) begin
                                n_state = S_REC_RD;
                            end
                        end
                        K_BIN: begin
                            n_state = (d_ok && h_ok && t_ok) ? S_WALK : S_EMIT;
                        end
                        K_TOTAL: begin
                            n_fix_d = 1'b0;
                            n_fix_h = 1'b0;
                            n_fix_t = 1'b0;
                            n_state = S_WALK;
                        end
                        K_HOUR: begin
                            n_fix_d = 1'b0;
                            n_fix_t = 1'b0;
                            n_state = h_ok ? S_WALK : S_EMIT;
                        end
                        K_TYPE: begin
                            n_fix_d = 1'b0;
                            n_fix_h = 1'b0;
                            n_state = t_ok ? S_WALK : S_EMIT;
                        end
                        K_TYPE_DAY: begin
                            n_fix_h = 1'b0;
                            n_state = (t_ok && d_ok) ? S_WALK : S_EMIT;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                    n_d = n_fix_d ? DW'(i_day) : '0;
                    n_h = n_fix_h ? HW'(i_hour) : '0;
                    n_t = n_fix_t ? TW'(i_op_type) : '0;
                end
            end
            S_CLEAR, S_WALK: begin
                if (r_state == S_CLEAR) begin
                    o_we = 1'b1;
                end else begin
                    n_rd_pend = 1'b1;
                end
                // type steps fastest, then hour, then day
                if (!t_end) begin
                    n_t = r_t + 1'b1;
                end else begin
                    n_t = r_fix_t ? r_t : '0;
                    if (!h_end) begin
                        n_h = r_h + 1'b1;
                    end else begin
                        n_h = r_fix_h ? r_h : '0;
                        if (!d_end) begin
                            n_d = r_d + 1'b1;
                        end else begin
                            n_d = r_fix_d ? r_d : '0;
                        end
                    end
                end
                if (all_end) begin
                    n_state = (r_state == S_CLEAR) ? S_IDLE : S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                o_ctl.emit = 1'b1;
                n_state    = S_IDLE;
            end
            S_REC_RD: begin
                n_state = S_REC_WR;
            end
            S_REC_WR: begin
                o_we    = 1'b1;
                o_wdata = (i_rdata == BIN_MAX) ? i_rdata : i_rdata + 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_d       <= '0;
            r_h       <= '0;
            r_t       <= '0;
            r_fix_d   <= 1'b0;
            r_fix_h   <= 1'b0;
            r_fix_t   <= 1'b0;
            r_rd_pend <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_d       <= n_d;
            r_h       <= n_h;
            r_t       <= n_t;
            r_fix_d   <= n_fix_d;
            r_fix_h   <= n_fix_h;
            r_fix_t   <= n_fix_t;
            r_rd_pend <= n_rd_pend;
        end
    end

    a_query_holds_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_kind == K_BIN || i_kind == K_TOTAL || i_kind == K_HOUR ||
                    i_kind == K_TYPE || i_kind == K_TYPE_DAY)) |=> o_busy)
        else $error("query accepted but sequencer returned to idle");

    a_write_only_clear_or_record: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_we |-> (r_state == S_CLEAR || r_state == S_REC_WR))
        else $error("memory write outside clear pass or record update");

    a_ctl_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_ctl.add && (o_ctl.clr || o_ctl.emit)))
        else $error("accumulator add overlaps clear or emit");

endmodule

@@ design/ehss_acc.sv @@
module ehss_acc (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  ehss_pkg::t_acc_ctl            i_ctl,
    input  logic [ehss_pkg::BIN_W-1:0]    i_rdata,
    output logic                         o_valid,
    output logic [ehss_pkg::TOTAL_W-1:0]  o_total
);
    import ehss_pkg::*;

    logic [TOTAL_W-1:0] r_acc, n_acc;
    logic [TOTAL_W-1:0] r_total;
    logic               r_valid;
    logic [TOTAL_W:0]   sum;

    assign sum = {1'b0, r_acc} + (TOTAL_W + 1)'(i_rdata);

    always_comb begin
        n_acc = r_acc;
        if (i_ctl.clr) begin
            n_acc = '0;
        end else if (i_ctl.add) begin
            // saturate at the top of the result range
            n_acc = sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_acc   <= n_acc;
            r_valid <= i_ctl.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.emit) begin
            r_total <= r_acc;
        end
    end

    assign o_valid = r_valid;
    assign o_total = r_total;

    a_strobe_follows_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(i_ctl.emit))
        else $error("result strobe without emit");

    a_acc_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.add && !i_ctl.clr) |=> (r_acc >= $past(r_acc)))
        else $error("accumulator decreased on add");

endmodule

@@ design/event_histogram_slice_sums.sv @@
// a query walks its bins, one bin read per cycle, then passes the drain and emit states;
// the result strobe is registered after emit; a query with an out-of-range selector goes
// straight to emit; busy stays high until idle, so the next item waits; the single memory
// port sets throughput, grand total 576 reads; a record item reads, modifies and writes
// back its bin and gives no result; reset clears control, then a clearing pass zeroes
// every bin (576 at defaults) with busy high; the receiver cannot stall the result strobe
module event_histogram_slice_sums #(
    parameter int DAYS       = 8,
    parameter int HOURS      = 24,
    parameter int TYPE_COUNT = 3
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [ehss_pkg::KIND_W-1:0]   i_kind,
    input  logic [ehss_pkg::TYPE_W-1:0]   i_op_type,
    input  logic [ehss_pkg::HOUR_W-1:0]   i_hour,
    input  logic [ehss_pkg::DAY_W-1:0]    i_day,
    output logic                         o_valid,
    output logic [ehss_pkg::TOTAL_W-1:0]  o_total
);
    import ehss_pkg::*;

    localparam int DEPTH = DAYS * HOURS * TYPE_COUNT;
    localparam int AW    = DEPTH > 1 ? $clog2(DEPTH) : 1;

    logic             mem_we;
    logic [AW-1:0]    mem_addr;
    logic [BIN_W-1:0] mem_wdata;
    logic [BIN_W-1:0] mem_rdata;
    t_acc_ctl         acc_ctl;

    ehss_seq #(
        .DAYS       (DAYS),
        .HOURS      (HOURS),
        .TYPE_COUNT (TYPE_COUNT)
    ) u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .o_busy    (busy),
        .i_kind    (i_kind),
        .i_op_type (i_op_type),
        .i_hour    (i_hour),
        .i_day     (i_day),
        .i_rdata   (mem_rdata),
        .o_we      (mem_we),
        .o_addr    (mem_addr),
        .o_wdata   (mem_wdata),
        .o_ctl     (acc_ctl)
    );

    ehss_ram #(
        .WIDTH (BIN_W),
        .DEPTH (DEPTH)
    ) u_bins (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_addr  (mem_addr),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

    ehss_acc u_acc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (acc_ctl),
        .i_rdata (mem_rdata),
        .o_valid (o_valid),
        .o_total (o_total)
    );

endmodule

@@ tb/sv/tb_event_histogram_slice_sums.sv @@
module tb_event_histogram_slice_sums;
    timeunit 1ns;
    timeprecision 1ps;

    import ehss_pkg::*;

    localparam int DAYS       = 8;
    localparam int HOURS      = 24;
    localparam int TYPE_COUNT = 3;
    localparam int BIN_COUNT  = DAYS * HOURS * TYPE_COUNT;

    localparam int RANDOM_ITEMS = 900;
    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int DRAIN_CYCLES = 600;

    // kind codes the block has no use for
    localparam logic [KIND_W-1:0] K_SPARE_A = 3'd6;
    localparam logic [KIND_W-1:0] K_SPARE_B = 3'd7;

    logic                i_clk;
    logic                i_rst_n;
    logic                start;
    logic                busy;
    logic [KIND_W-1:0]   i_kind;
    logic [TYPE_W-1:0]   i_op_type;
    logic [HOUR_W-1:0]   i_hour;
    logic [DAY_W-1:0]    i_day;
    logic                o_valid;
    logic [TOTAL_W-1:0]  o_total;

    logic [BIN_W-1:0]    event_counts [BIN_COUNT];
    logic [TOTAL_W-1:0]  pending_totals [$];
    int                  mismatch_count;
    int                  cycle_count;
    int                  burst_left;

    event_histogram_slice_sums #(
        .DAYS       (DAYS),
        .HOURS      (HOURS),
        .TYPE_COUNT (TYPE_COUNT)
    ) DUT (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .busy      (busy),
        .i_kind    (i_kind),
        .i_op_type (i_op_type),
        .i_hour    (i_hour),
        .i_day     (i_day),
        .o_valid   (o_valid),
        .o_total   (o_total)
    );

    always #2 i_clk = ~i_clk;

    function automatic int bin_index(int d, int h, int t);
        return (d * HOURS + h) * TYPE_COUNT + t;
    endfunction

    function automatic logic [TOTAL_W-1:0] slice_sum(bit fix_d, int d, bit fix_h, int h,
                                                    bit fix_t, int t);
        longint unsigned acc;
        acc = 0;
        for (int di = 0; di < DAYS; di++) begin
            for (int hi = 0; hi < HOURS; hi++) begin
                for (int ti = 0; ti < TYPE_COUNT; ti++) begin
                    if ((!fix_d || di == d) && (!fix_h || hi == h) && (!fix_t || ti == t))
                        acc += 64'(event_counts[bin_index(di, hi, ti)]);
                end
            end
        end
        if (acc > longint'(TOTAL_MAX))
            return TOTAL_MAX;
        return acc[TOTAL_W-1:0];
    endfunction

    // updates the histogram copy; returns 1 when the item yields a total
    function automatic bit histogram_step(logic [KIND_W-1:0] kind, logic [TYPE_W-1:0] t,
                                          logic [HOUR_W-1:0] h, logic [DAY_W-1:0] d,
                                          output logic [TOTAL_W-1:0] sum);
        bit t_ok;
        bit h_ok;
        bit d_ok;
        int idx;
        t_ok = t < TYPE_COUNT;
        h_ok = h < HOURS;
        d_ok = d < DAYS;
        sum  = '0;
        case (kind)
            K_RECORD: begin
                if (t_ok && h_ok && d_ok) begin
                    idx = bin_index(int'(d), int'(h), int'(t));
                    if (event_counts[idx] != BIN_MAX)
                        event_counts[idx] = event_counts[idx] + 1'b1;
                end
                return 1'b0;
            end
            K_BIN: begin
                if (t_ok && h_ok && d_ok)
                    sum = TOTAL_W'(event_counts[bin_index(int'(d), int'(h), int'(t))]);
            end
            K_TOTAL:    sum = slice_sum(1'b0, 0, 1'b0, 0, 1'b0, 0);
            K_HOUR:     if (h_ok) sum = slice_sum(1'b0, 0, 1'b1, int'(h), 1'b0, 0);
            K_TYPE:     if (t_ok) sum = slice_sum(1'b0, 0, 1'b0, 0, 1'b1, int'(t));
            K_TYPE_DAY: if (t_ok && d_ok) sum = slice_sum(1'b1, int'(d), 1'b0, 0, 1'b1, int'(t));
            default:    return 1'b0;
        endcase
        return 1'b1;
    endfunction

    task automatic send_item(logic [KIND_W-1:0] kind, logic [TYPE_W-1:0] t,
                             logic [HOUR_W-1:0] h, logic [DAY_W-1:0] d);
        logic [TOTAL_W-1:0] sum;
        @(negedge i_clk);
        if (burst_left == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge i_clk);
            // about one burst in four is a long run with no gaps
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 150)
                                                     : $urandom_range(1, 20);
        end
        start     <= 1'b1;
        i_kind    <= kind;
        i_op_type <= t;
        i_hour    <= h;
        i_day     <= d;
        do @(posedge i_clk); while (busy);
        if (histogram_step(kind, t, h, d, sum))
            pending_totals.push_back(sum);
        burst_left--;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (pending_totals.size() == 0) begin
                $error("total: unexpected result %0d, none expected", o_total);
                mismatch_count++;
            end else begin
                if (o_total !== pending_totals[0]) begin
                    $error("total: expected %0d, actual %0d", pending_totals[0], o_total);
                    mismatch_count++;
                end
                void'(pending_totals.pop_front());
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_event_histogram_slice_sums failed");
            $finish;
        end
    end

    // the store must read back as zero after the clearing pass
    task automatic test_cleared_store();
        send_item(K_TOTAL, 2'd0, 5'd0, 3'd0);
        send_item(K_BIN, 2'd2, 5'd23, 3'd7);
    endtask

    task automatic test_corner_items();
        send_item(K_RECORD, 2'd0, 5'd0, 3'd0);
        send_item(K_RECORD, 2'd0, 5'd0, 3'd0);
        send_item(K_RECORD, 2'd2, 5'd23, 3'd7);
        send_item(K_RECORD, 2'd1, 5'd12, 3'd3);
        // out-of-range records are dropped
        send_item(K_RECORD, 2'd3, 5'd5, 3'd1);
        send_item(K_RECORD, 2'd1, 5'd24, 3'd1);
        send_item(K_RECORD, 2'd1, 5'd31, 3'd6);
        send_item(K_SPARE_A, 2'd0, 5'd0, 3'd0);
        send_item(K_SPARE_B, 2'd3, 5'd31, 3'd7);
        send_item(K_BIN, 2'd0, 5'd0, 3'd0);
        send_item(K_BIN, 2'd2, 5'd23, 3'd7);
        send_item(K_BIN, 2'd3, 5'd0, 3'd0);
        send_item(K_TOTAL, 2'd3, 5'd31, 3'd7);
        send_item(K_HOUR, 2'd3, 5'd0, 3'd7);
        send_item(K_HOUR, 2'd0, 5'd23, 3'd0);
        send_item(K_HOUR, 2'd1, 5'd31, 3'd2);
        // unused selectors carry junk; some selectors are out of range
        send_item(K_TYPE, 2'd0, 5'd31, 3'd7);
        send_item(K_TYPE, 2'd3, 5'd0, 3'd0);
        send_item(K_TYPE_DAY, 2'd2, 5'd30, 3'd7);
        send_item(K_TYPE_DAY, 2'd3, 5'd0, 3'd0);
        send_item(K_TYPE_DAY, 2'd1, 5'd0, 3'd3);
    endtask

    task automatic test_random_traffic();
        int                counted;
        int                pick;
        bit                hot;
        logic [KIND_W-1:0] kind;
        logic [TYPE_W-1:0] t;
        logic [HOUR_W-1:0] h;
        logic [DAY_W-1:0]  d;
        counted = 0;
        while (counted < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 99);
            hot  = 1'($urandom_range(0, 1));
            t    = TYPE_W'($urandom_range(0, TYPE_COUNT - 1));
            h    = HOUR_W'($urandom_range(0, HOURS - 1));
            d    = DAY_W'($urandom_range(0, DAYS - 1));
            // a few hot bins so that counts grow past one
            if (hot) begin
                d = DAY_W'($urandom_range(0, 1));
                h = HOUR_W'($urandom_range(0, 2));
            end
            if (pick < 45)      kind = K_RECORD;
            else if (pick < 57) kind = K_BIN;
            else if (pick < 62) kind = K_TOTAL;
            else if (pick < 72) kind = K_HOUR;
            else if (pick < 82) kind = K_TYPE;
            else if (pick < 92) kind = K_TYPE_DAY;
            else begin
                // noise: any kind, selectors over their full width
                kind = KIND_W'($urandom_range(0, 7));
                t    = TYPE_W'($urandom_range(0, 3));
                h    = HOUR_W'($urandom_range(0, 31));
                d    = DAY_W'($urandom_range(0, 7));
            end
            case (kind)
                K_TOTAL: begin
                    t = TYPE_W'($urandom_range(0, 3));
                    h = HOUR_W'($urandom_range(0, 31));
                end
                K_HOUR:     t = TYPE_W'($urandom_range(0, 3));
                K_TYPE:     h = HOUR_W'($urandom_range(0, 31));
                K_TYPE_DAY: h = HOUR_W'($urandom_range(0, 31));
                default: ;
            endcase
            send_item(kind, t, h, d);
            if (!(kind == K_SPARE_A || kind == K_SPARE_B ||
                  (kind == K_RECORD && (t >= TYPE_COUNT || h >= HOURS || d >= DAYS))))
                counted++;
        end
    endtask

    initial begin
        i_clk          = 1'b0;
        i_rst_n        = 1'b0;
        start          = 1'b0;
        i_kind         = '0;
        i_op_type      = '0;
        i_hour         = '0;
        i_day          = '0;
        mismatch_count = 0;
        cycle_count    = 0;
        burst_left     = 0;
        foreach (event_counts[i]) event_counts[i] = '0;

        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_cleared_store();
        test_corner_items();
        test_random_traffic();

        @(negedge i_clk);
        start <= 1'b0;
        while (pending_totals.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0)
            $display("tb_event_histogram_slice_sums passed");
        else
            $display("tb_event_histogram_slice_sums failed");
        $finish;
    end

endmodule

@@ files.f @@
design/ehss_pkg.sv
design/ehss_ram.sv
design/ehss_seq.sv
design/ehss_acc.sv
design/event_histogram_slice_sums.sv
tb/sv/tb_event_histogram_slice_sums.sv
